### hdl/fpa_pkg.sv
package fpa_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field widths
  localparam int TS_W    = 64;
  localparam int MIN_W   = 30;
  localparam int CNT_W   = 7;
  localparam int DELTA_W = 32;
  localparam int RATE_W  = 38;

  // Averaging count limits; the count register is 7 bits wide
  localparam int COUNT_MAX     = (RING_DEPTH < 127) ? RING_DEPTH : 127;
  localparam int COUNT_DEFAULT = 10;
  localparam int COUNT_RST_INT = (COUNT_DEFAULT > COUNT_MAX) ? COUNT_MAX : COUNT_DEFAULT;
  localparam logic [CNT_W-1:0] AVG_COUNT_RST = CNT_W'(COUNT_RST_INT);
  localparam logic [CNT_W-1:0] AVG_COUNT_MAX = CNT_W'(COUNT_MAX);

  // Read pointer over the averaged entries and the exact ring sum
  localparam int PTR_W = $clog2(COUNT_MAX + 1);
  localparam int SUM_W = DELTA_W + PTR_W;
  localparam int CMP_W = IDX_W + CNT_W + 1;

  // Shared divider
  localparam int DIV_W     = (SUM_W > RATE_W) ? SUM_W : RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Constants
  localparam logic [MIN_W-1:0]  MIN_FRAME_MAX = 30'd1000000000;
  localparam logic [RATE_W-1:0] RATE_NUM      = 38'd256000000000;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FRAME = 2'd0,
    REG_AVG_COUNT = 2'd1,
    REG_START_TS  = 2'd2
  } reg_idx_e;

  // Ring memory access
  typedef struct packed {
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DELTA_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
  } ring_req_t;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DELTA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/fpa_if.sv
// Frame event word: one timestamp
interface fpa_in_if;
  import fpa_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] now_ns;
  modport source (output valid, output now_ns, input ready);
  modport sink (input valid, input now_ns, output ready);
endinterface

// Register write word
interface fpa_cfg_if;
  import fpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// Result word
interface fpa_out_if;
  import fpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    raw_delta_ns;
  logic [TS_W-1:0]    frame_delta_ns;
  logic [MIN_W-1:0]   wait_ns;
  logic [TS_W-1:0]    frame_count;
  logic [DELTA_W-1:0] average_delta_ns;
  logic [RATE_W-1:0]  average_rate_q8;
  logic               rate_invalid;
  modport source (output valid, output raw_delta_ns, output frame_delta_ns,
                  output wait_ns, output frame_count, output average_delta_ns,
                  output average_rate_q8, output rate_invalid, input ready);
  modport sink (input valid, input raw_delta_ns, input frame_delta_ns,
                input wait_ns, input frame_count, input average_delta_ns,
                input average_rate_q8, input rate_invalid, output ready);
endinterface

### hdl/fpa_ring.sv
module fpa_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fpa_pkg::ring_req_t        req_i,
  output logic [fpa_pkg::DELTA_W-1:0] rd_data_o
);
  import fpa_pkg::*;

  logic [DELTA_W-1:0]    mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_q;
  logic [DELTA_W-1:0]    rd_q;
  logic                  rd_vld_q;

  // Delta storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  // Written flags; an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

### hdl/fpa_div.sv
module fpa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpa_pkg::div_req_t req_i,
  output fpa_pkg::div_rsp_t rsp_o
);
  import fpa_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [DELTA_W-1:0]   rem_q;
  logic [DELTA_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DELTA_W:0]     shifted;
  logic [DELTA_W:0]     diff;
  logic                 ge;

  // One restoring step: bring in the next dividend bit, try the subtract
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DELTA_W-1:0] : shifted[DELTA_W-1:0];
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= DIV_CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### hdl/frame_pacer_with_average.sv
// Frame pacer with a moving average of frame times. Each input word is one
// frame event with a nanosecond timestamp; each produces exactly one result
// word. One event is in work at a time: the input is ready only while the
// block is idle, and a finished result waits in the output register while the
// next event is taken. An event goes through these steps in order: take the
// delta; update the reference, frame counter and ring; sum the ring through its
// single read port; run the average division and then the rate division in the
// shared bit-serial divider (the second is skipped when the average is zero);
// and load the output register. The ring needs no clearing pass after reset:
// per-entry written flags make every unwritten entry read as zero. Register
// writes are always ready; writing the start timestamp also reloads the
// reference time.
module frame_pacer_with_average (
  input logic    clk_i,
  input logic    rst_ni,
  fpa_in_if.sink   in_i,
  fpa_cfg_if.sink  cfg_i,
  fpa_out_if.source res_o
);
  import fpa_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CALC     = 6'b000010,
    ST_SUM      = 6'b000100,
    ST_DIV_AVG  = 6'b001000,
    ST_DIV_RATE = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Registers and state
  logic [MIN_W-1:0]   min_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TS_W-1:0]    ref_q, ref_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [TS_W-1:0]    frames_q, frames_d;

  // Per-event working values
  logic [TS_W-1:0]    raw_q, raw_d;
  logic [TS_W-1:0]    used_q, used_d;
  logic [MIN_W-1:0]   wait_q, wait_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [DELTA_W-1:0] avg_q, avg_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic               inv_q, inv_d;

  // Output register
  logic               ovld_q, ovld_d;
  logic               oload;
  logic [TS_W-1:0]    o_raw_q, o_used_q, o_frames_q;
  logic [MIN_W-1:0]   o_wait_q;
  logic [DELTA_W-1:0] o_avg_q;
  logic [RATE_W-1:0]  o_rate_q;
  logic               o_inv_q;

  // Update step helpers
  logic               lt;
  logic [TS_W-1:0]    used_c;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W:0]     idx_nxt;
  logic               idx_wrap;
  logic               issue;
  logic [DELTA_W-1:0] quo_avg;

  ring_req_t          ring_req;
  logic [DELTA_W-1:0] ring_rd;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic in_acc;
  logic cfg_acc;
  logic [MIN_W-1:0] cfg_min;
  logic [CNT_W-1:0] cfg_cnt;

  fpa_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_rd)
  );

  fpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  // Register write clamps
  assign cfg_min = (cfg_i.data[MIN_W-1:0] > MIN_FRAME_MAX) ? MIN_FRAME_MAX
                                                           : cfg_i.data[MIN_W-1:0];
  always_comb begin
    cfg_cnt = cfg_i.data[CNT_W-1:0];
    if (cfg_cnt == '0) begin
      cfg_cnt = CNT_W'(1);
    end else if (cfg_cnt > AVG_COUNT_MAX) begin
      cfg_cnt = AVG_COUNT_MAX;
    end
  end

  // Frame time raise and ring slot selection
  assign lt       = (raw_q < TS_W'(min_q));
  assign used_c   = lt ? TS_W'(min_q) : raw_q;
  assign wr_addr  = ({1'b0, idx_q} >= (IDX_W+1)'(RING_DEPTH)) ? '0 : idx_q;
  assign idx_nxt  = {1'b0, wr_addr} + 1'b1;
  assign idx_wrap = (CMP_W'(idx_nxt) >= CMP_W'(cnt_q)) ||
                    (CMP_W'(idx_nxt) >= CMP_W'(RING_DEPTH));
  assign issue    = (CMP_W'(ptr_q) < CMP_W'(cnt_q));
  assign quo_avg  = div_rsp.quotient[DELTA_W-1:0];

  // Sequencer
  always_comb begin
    state_d  = state_q;
    ref_d    = ref_q;
    idx_d    = idx_q;
    frames_d = frames_q;
    raw_d    = raw_q;
    used_d   = used_q;
    wait_d   = wait_q;
    ptr_d    = ptr_q;
    pend_d   = 1'b0;
    sum_d    = sum_q;
    avg_d    = avg_q;
    rate_d   = rate_q;
    inv_d    = inv_q;
    oload    = 1'b0;
    ovld_d   = ovld_q && !res_o.ready;

    ring_req.wr_en   = 1'b0;
    ring_req.wr_addr = wr_addr;
    ring_req.wr_data = (|used_c[TS_W-1:DELTA_W]) ? '1 : used_c[DELTA_W-1:0];
    ring_req.rd_en   = 1'b0;
    ring_req.rd_addr = IDX_W'(ptr_q);

    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(sum_q);
    div_req.divisor  = DELTA_W'(cnt_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          raw_d   = in_i.now_ns - ref_q;
          ptr_d   = '0;
          sum_d   = '0;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        used_d         = used_c;
        wait_d         = lt ? (min_q - raw_q[MIN_W-1:0]) : '0;
        ref_d          = ref_q + used_c;
        ring_req.wr_en = 1'b1;
        idx_d          = idx_wrap ? '0 : idx_nxt[IDX_W-1:0];
        frames_d       = frames_q + 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        // read one entry a cycle, add it in as it returns
        if (issue) begin
          ring_req.rd_en = 1'b1;
          ptr_d          = ptr_q + 1'b1;
          pend_d         = 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + SUM_W'(ring_rd);
        end
        if (!issue && !pend_q) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (div_rsp.done) begin
          avg_d = quo_avg;
          if (quo_avg == '0) begin
            rate_d  = RATE_NUM;
            inv_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(RATE_NUM);
            div_req.divisor  = quo_avg;
            inv_d            = 1'b0;
            state_d          = ST_DIV_RATE;
          end
        end
      end
      ST_DIV_RATE: begin
        if (div_rsp.done) begin
          rate_d  = div_rsp.quotient[RATE_W-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovld_q || res_o.ready) begin
          oload   = 1'b1;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a start timestamp write reloads the reference at once
    if (cfg_acc && (cfg_i.index == REG_START_TS)) begin
      ref_d = cfg_i.data;
    end
  end

  // Control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      min_q    <= '0;
      cnt_q    <= AVG_COUNT_RST;
      ref_q    <= '0;
      idx_q    <= '0;
      frames_q <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ref_q    <= ref_d;
      idx_q    <= idx_d;
      frames_q <= frames_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      ovld_q   <= ovld_d;
      if (cfg_acc) begin
        case (cfg_i.index)
          REG_MIN_FRAME: min_q <= cfg_min;
          REG_AVG_COUNT: cnt_q <= cfg_cnt;
          default: begin
          end
        endcase
      end
    end
  end

  // Working values and output word
  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    used_q <= used_d;
    wait_q <= wait_d;
    sum_q  <= sum_d;
    avg_q  <= avg_d;
    rate_q <= rate_d;
    inv_q  <= inv_d;
    if (oload) begin
      o_raw_q    <= raw_q;
      o_used_q   <= used_q;
      o_wait_q   <= wait_q;
      o_frames_q <= frames_q;
      o_avg_q    <= avg_q;
      o_rate_q   <= rate_q;
      o_inv_q    <= inv_q;
    end
  end

  assign res_o.valid            = ovld_q;
  assign res_o.raw_delta_ns     = o_raw_q;
  assign res_o.frame_delta_ns   = o_used_q;
  assign res_o.wait_ns          = o_wait_q;
  assign res_o.frame_count      = o_frames_q;
  assign res_o.average_delta_ns = o_avg_q;
  assign res_o.average_rate_q8  = o_rate_q;
  assign res_o.rate_invalid     = o_inv_q;

endmodule

### hdl/fpa_checker.sv
module fpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [fpa_pkg::TS_W-1:0]      raw_i,
  input logic [fpa_pkg::TS_W-1:0]      used_i,
  input logic [fpa_pkg::MIN_W-1:0]     wait_i,
  input logic [fpa_pkg::DELTA_W-1:0]   avg_i,
  input logic [fpa_pkg::RATE_W-1:0]    rate_i,
  input logic                          inv_i
);
  import fpa_pkg::*;

  // one event in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while an event is in work");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(avg_i) && $stable(raw_i))
    else $error("result word changed while stalled");

  // zero average flags the rate and saturates it
  a_zero_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (inv_i == (avg_i == '0)) && (!inv_i || (rate_i == RATE_NUM)))
    else $error("rate flag does not match the average");

  // the used delta is the raw delta plus the wait owed
  a_wait_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (wait_i == '0) || (used_i == raw_i + TS_W'(wait_i)))
    else $error("frame delta does not match raw delta and wait");

endmodule

bind frame_pacer_with_average fpa_checker u_fpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .raw_i       (res_o.raw_delta_ns),
  .used_i      (res_o.frame_delta_ns),
  .wait_i      (res_o.wait_ns),
  .avg_i       (res_o.average_delta_ns),
  .rate_i      (res_o.average_rate_q8),
  .inv_i       (res_o.rate_invalid)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fpa_pkg::*;

  // One result word as the block reports it
  typedef struct packed {
    logic [TS_W-1:0]    raw_delta_ns;
    logic [TS_W-1:0]    frame_delta_ns;
    logic [MIN_W-1:0]   wait_ns;
    logic [TS_W-1:0]    frame_count;
    logic [DELTA_W-1:0] average_delta_ns;
    logic [RATE_W-1:0]  average_rate_q8;
    logic               rate_invalid;
  } pacing_t;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int unsigned FRAME_60HZ_NS = 16_666_667;
  localparam int unsigned RANDOM_FRAMES = 600;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned DRAIN_CYCLES  = 200;

  // Pacing predictor and store of expected result words
  class pacing_scoreboard;
    logic [MIN_W-1:0]   min_frame;
    logic [CNT_W-1:0]   avg_count;
    logic [TS_W-1:0]    start_ts;
    logic [TS_W-1:0]    ref_time;
    logic [TS_W-1:0]    frames;
    logic [DELTA_W-1:0] ring [RING_DEPTH];
    int unsigned        ring_idx;
    pacing_t            pending_q[$];
    int unsigned        fails;

    function new();
      min_frame = '0;
      avg_count = AVG_COUNT_RST;
      start_ts  = '0;
      ref_time  = '0;
      frames    = '0;
      ring_idx  = 0;
      fails     = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [MIN_W-1:0] min_v;
      logic [CNT_W-1:0] cnt_v;
      min_v = data[MIN_W-1:0];
      cnt_v = data[CNT_W-1:0];
      case (reg_idx_e'(idx))
        REG_MIN_FRAME: begin
          min_frame = (min_v > MIN_FRAME_MAX) ? MIN_FRAME_MAX : min_v;
        end
        REG_AVG_COUNT: begin
          if (cnt_v == '0) cnt_v = CNT_W'(1);
          else if (cnt_v > AVG_COUNT_MAX) cnt_v = AVG_COUNT_MAX;
          avg_count = cnt_v;
        end
        REG_START_TS: begin
          start_ts = data;
          ref_time = data;
        end
        default: ;
      endcase
    endfunction

    // Work out the result word of one accepted frame event
    function void note_frame(logic [TS_W-1:0] now);
      pacing_t     want;
      logic [63:0] used;
      logic [63:0] sum;
      logic [63:0] avg;
      want = '0;
      want.raw_delta_ns = now - ref_time;
      used = want.raw_delta_ns;
      if (want.raw_delta_ns < 64'(min_frame)) begin
        want.wait_ns = MIN_W'(64'(min_frame) - want.raw_delta_ns);
        used = 64'(min_frame);
      end
      want.frame_delta_ns = used;
      ref_time += used;

      // long frames saturate in the ring; index wraps at count or depth
      if (ring_idx >= RING_DEPTH) ring_idx = 0;
      ring[ring_idx[IDX_W-1:0]] = (used > 64'hFFFF_FFFF) ? '1 : used[DELTA_W-1:0];
      ring_idx++;
      if (ring_idx >= avg_count || ring_idx >= RING_DEPTH) ring_idx = 0;
      frames++;
      want.frame_count = frames;

      sum = '0;
      for (int i = 0; i < RING_DEPTH && i < avg_count; i++) sum += ring[i[IDX_W-1:0]];
      avg = sum / 64'(avg_count);
      want.average_delta_ns = avg[DELTA_W-1:0];
      if (avg == 0) begin
        want.average_rate_q8 = RATE_NUM;
        want.rate_invalid    = 1'b1;
      end else begin
        want.average_rate_q8 = RATE_W'(64'(RATE_NUM) / avg);
        want.rate_invalid    = 1'b0;
      end
      pending_q.push_back(want);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(pacing_t got);
      pacing_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with none expected, frame_count %0d",
                 $time, got.frame_count);
        fails++;
        return;
      end
      want = pending_q.pop_front();
      check_field("raw_delta_ns", want.raw_delta_ns, got.raw_delta_ns);
      check_field("frame_delta_ns", want.frame_delta_ns, got.frame_delta_ns);
      check_field("wait_ns", 64'(want.wait_ns), 64'(got.wait_ns));
      check_field("frame_count", want.frame_count, got.frame_count);
      check_field("average_delta_ns", 64'(want.average_delta_ns),
                  64'(got.average_delta_ns));
      check_field("average_rate_q8", 64'(want.average_rate_q8),
                  64'(got.average_rate_q8));
      check_field("rate_invalid", 64'(want.rate_invalid), 64'(got.rate_invalid));
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fpa_in_if  in_bus ();
  fpa_cfg_if cfg_bus ();
  fpa_out_if res_bus ();

  frame_pacer_with_average DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  pacing_scoreboard sb;
  int unsigned in_gap_max  = 13;
  int unsigned out_gap_max = 13;
  int unsigned out_hold    = 0;
  int unsigned frames_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one frame word; called and returns at a falling edge, valid left high
  task automatic send_frame(input logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.now_ns <= ts;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_frame(ts);
    frames_sent++;
    @(negedge clk);
  endtask

  // Register write; valid is left high for back-to-back writes
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Drop the offer and wait until every result word is back
  task automatic settle();
    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly monotonic timestamps around the pacing limits, with some noise
  function automatic logic [TS_W-1:0] pick_timestamp();
    logic [TS_W-1:0] base;
    int unsigned     sel;
    base = sb.ref_time;
    sel  = $urandom_range(0, 99);
    if (sel < 40) return base + 64'($urandom_range(10_000_000, 40_000_000));
    if (sel < 55) return base + 64'($urandom_range(0, sb.min_frame));
    if (sel < 65) return base + 64'(sb.min_frame) + 64'($urandom_range(0, 2)) - 64'd1;
    if (sel < 75) return base + {24'h0, 8'($urandom_range(1, 255)), 32'($urandom)};
    if (sel < 80) return base - 64'($urandom_range(1, 1000));
    if (sel < 90) return {$urandom, $urandom};
    return base;
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       data[MIN_W-1:0] = '0;
      1:       data[MIN_W-1:0] = MIN_FRAME_MAX;
      2:       data[MIN_W-1:0] = '1;
      3:       data[MIN_W-1:0] = MIN_W'(FRAME_60HZ_NS);
      4:       data[MIN_W-1:0] = MIN_W'($urandom);
      default: data[MIN_W-1:0] = MIN_W'($urandom_range(0, 1000));
    endcase
    cfg_write(REG_MIN_FRAME, data);
    data = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       data[CNT_W-1:0] = 7'd1;
      1:       data[CNT_W-1:0] = 7'd64;
      2:       data[CNT_W-1:0] = 7'd127;
      3:       data[CNT_W-1:0] = 7'd0;
      4:       data[CNT_W-1:0] = CNT_W'($urandom_range(1, 64));
      default: data[CNT_W-1:0] = CNT_W'($urandom_range(0, 127));
    endcase
    cfg_write(REG_AVG_COUNT, data);
    case ($urandom_range(0, 9))
      0:       cfg_write(REG_START_TS, {$urandom, $urandom});
      1:       cfg_write(REG_START_TS, '0);
      2:       cfg_write(REG_START_TS, '1);
      3:       cfg_write(REG_UNUSED, {$urandom, $urandom});
      default: ;
    endcase
  endtask

  // Result side: random ready gaps, one long hold when asked
  task automatic collect_results();
    pacing_t     got;
    int unsigned gap;
    forever begin
      if (out_hold > 0) begin
        gap      = out_hold;
        out_hold = 0;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk);
      while (!res_bus.valid) @(posedge clk);
      got.raw_delta_ns     = res_bus.raw_delta_ns;
      got.frame_delta_ns   = res_bus.frame_delta_ns;
      got.wait_ns          = res_bus.wait_ns;
      got.frame_count      = res_bus.frame_count;
      got.average_delta_ns = res_bus.average_delta_ns;
      got.average_rate_q8  = res_bus.average_rate_q8;
      got.rate_invalid     = res_bus.rate_invalid;
      sb.check_result(got);
      @(negedge clk);
    end
  endtask

  initial begin
    int unsigned phase_len;
    int unsigned phase_num;
    sb             = new();
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.now_ns  = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_MIN_FRAME;
    cfg_bus.data   = '0;
    res_bus.ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      collect_results();
    join_none
    @(negedge clk);

    // Reset settings: zero delta, zero average, long frame, wrapped delta
    send_frame('0);
    send_frame(64'd5);
    send_frame('1);
    send_frame('0);
    settle();

    // Over-range minimum, count of zero, start near the top, unknown index
    cfg_write(REG_MIN_FRAME, '1);
    cfg_write(REG_AVG_COUNT, 64'hFFFF_FFFF_FFFF_FF80);
    cfg_write(REG_START_TS, 64'hFFFF_FFFF_FFFF_FF00);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    send_frame(sb.ref_time + 64'd1);
    send_frame(sb.ref_time + 64'(MIN_FRAME_MAX));
    send_frame(sb.ref_time + 64'(MIN_FRAME_MAX) + 64'd1);
    send_frame(sb.ref_time);
    settle();

    // Count written over range and clamped to the ring depth, frames at 60 Hz
    cfg_write(REG_MIN_FRAME, '0);
    cfg_write(REG_AVG_COUNT, 64'd127);
    cfg_write(REG_START_TS, '0);
    cfg_bus.valid <= 1'b0;
    repeat (6) send_frame(sb.ref_time + 64'(FRAME_60HZ_NS));
    settle();

    // Count lowered below the ring index
    cfg_write(REG_AVG_COUNT, 64'd3);
    cfg_bus.valid <= 1'b0;
    repeat (2) send_frame(sb.ref_time + 64'(FRAME_60HZ_NS));
    settle();

    // Minimum with junk in the high data bits; zero raw deltas owe a wait
    cfg_write(REG_AVG_COUNT, 64'd64);
    cfg_write(REG_MIN_FRAME, 64'hFFFF_FFFF_C000_0005);
    cfg_bus.valid <= 1'b0;
    repeat (2) send_frame(sb.ref_time);
    settle();

    // Random phases, each under its own settings and idling
    frames_sent = 0;
    phase_num   = 0;
    while (frames_sent < RANDOM_FRAMES) begin
      random_settings();
      cfg_bus.valid <= 1'b0;
      phase_len   = $urandom_range(10, 60);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 13;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      if (phase_num == 2) begin
        // sender keeps offering while the receiver holds off
        in_gap_max = 0;
        out_hold   = LONG_HOLD;
      end
      repeat (phase_len) send_frame(pick_timestamp());
      settle();
      phase_num++;
    end

    out_gap_max = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("frame_pacer_with_average test passed");
    end else begin
      $display("frame_pacer_with_average test failed");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("frame_pacer_with_average test failed");
    $finish;
  end

endmodule
